@@ rtl/udp_dmx_pkg.sv @@
package udp_dmx_pkg;

	// defaults for the top-level parameters
	localparam int FILTER_ENTRIES_DEF = 16;
	localparam int SOCKET_ENTRIES_DEF = 16;
	localparam int QUEUE_LIMIT_DEF    = 2;

	// index and queue widths sized for the top of each parameter range (64 entries, limit 15)
	localparam int SIDX_W = 6;
	localparam int QCNT_W = 4;
	localparam int HITS_W = 16;

	typedef enum logic [2:0] {
		OP_DATAGRAM = 3'd0,
		OP_FILTER   = 3'd1,
		OP_BIND     = 3'd2,
		OP_CLOSE    = 3'd3,
		OP_CONSUME  = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		D_FILTERED = 4'd0,
		D_HANDLER  = 4'd1,
		D_QUEUED   = 4'd2,
		D_BAD_LEN  = 4'd3,
		D_BAD_SUM  = 4'd4,
		D_NO_SOCK  = 4'd5,
		D_FULL     = 4'd6,
		D_DONE     = 4'd7,
		D_IN_USE   = 4'd8,
		D_EMPTY    = 4'd9,
		D_BOUND    = 4'd10
	} disp_t;

	typedef enum logic [1:0] {
		SC_QUEUE   = 2'd0,
		SC_DEQUEUE = 2'd1,
		SC_BIND    = 2'd2,
		SC_CLOSE   = 2'd3
	} sc_kind_t;

	// item fields broadcast to every cell while a token walks the row
	typedef struct packed {
		logic [SIDX_W-1:0] sidx;
		logic [15:0]       sport;
		logic [15:0]       dport;
		logic [31:0]       daddr;
	} probe_t;

	// token walking the filter row
	typedef struct packed {
		logic              vld;
		logic              any;
		logic [HITS_W-1:0] hits;
	} ftok_t;

	// token walking the socket row
	typedef struct packed {
		logic              vld;
		logic              found;
		logic [SIDX_W-1:0] sel;
		logic              handler;
		logic [QCNT_W-1:0] selq;
		logic              in_use;
		logic              a_used;
		logic              a_portnz;
		logic [QCNT_W-1:0] a_q;
	} stok_t;

	typedef struct packed {
		logic              en;
		logic [SIDX_W-1:0] idx;
		logic              used;
		logic [15:0]       src;
		logic [15:0]       dst;
	} fcmd_t;

	typedef struct packed {
		logic              en;
		sc_kind_t          kind;
		logic [SIDX_W-1:0] idx;
		logic [15:0]       port;
		logic [31:0]       addr;
		logic              handler;
	} scmd_t;

endpackage

@@ rtl/udp_dmx_ifs.sv @@
interface udp_dmx_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [3:0]  entry_index;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [31:0] dest_address;
	logic [15:0] packet_length;
	logic [15:0] udp_length;
	logic        checksum_failed;
	logic        has_handler;
	logic        entry_valid;

	modport source (
		output valid, operation, entry_index, source_port, dest_port, dest_address,
			packet_length, udp_length, checksum_failed, has_handler, entry_valid,
		input ready
	);
	modport sink (
		input valid, operation, entry_index, source_port, dest_port, dest_address,
			packet_length, udp_length, checksum_failed, has_handler, entry_valid,
		output ready
	);
endinterface

interface udp_dmx_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  disposition;
	logic [15:0] filter_hits;
	logic [3:0]  socket_index;
	logic [1:0]  queue_count;
	logic [31:0] received_count;
	logic [31:0] dropped_count;

	modport source (
		output valid, disposition, filter_hits, socket_index, queue_count,
			received_count, dropped_count,
		input ready
	);
	modport sink (
		input valid, disposition, filter_hits, socket_index, queue_count,
			received_count, dropped_count,
		output ready
	);
endinterface

@@ rtl/udp_port_demux_core.sv @@
// channel  dir  handshake       payload
// req      in   valid / ready   operation, entry index, ports, address, lengths, flags
// rsp      out  valid / ready   disposition, filter hits, socket index, queue count, totals
// cfg      in   cfg_we only     check_enable in cfg_wdata
//
// one item at a time: the next accept waits for the token walking the longer cell row
// to reach the row end and for the item to be retired
// arst_n clears both tables, the totals and check_enable to 1
// a new item is taken while the previous result still waits in the rsp register
// a stalled rsp holds the finished item in its final step until the register frees
module udp_port_demux_core #(
	parameter int FILTER_ENTRIES = udp_dmx_pkg::FILTER_ENTRIES_DEF,
	parameter int SOCKET_ENTRIES = udp_dmx_pkg::SOCKET_ENTRIES_DEF,
	parameter int QUEUE_LIMIT    = udp_dmx_pkg::QUEUE_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	udp_dmx_req_if.sink         req,
	udp_dmx_rsp_if.source       rsp,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import udp_dmx_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;

	// item held for the whole walk
	op_t         op_q;
	logic [3:0]  idx_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [31:0] daddr_q;
	logic        len_bad_q;
	logic        sum_bad_q;
	logic        handler_q;
	logic        evalid_q;

	logic        check_q;
	logic        start_q;
	logic        f_got_q;
	logic        s_got_q;
	ftok_t       f_res_q;
	stok_t       s_res_q;
	logic [31:0] rx_q;
	logic [31:0] drop_q;

	// result register
	logic        out_vld_q;
	disp_t       disp_q;
	logic [15:0] hits_q;
	logic [3:0]  sidx_q;
	logic [1:0]  qcnt_q;
	logic [31:0] rxo_q;
	logic [31:0] dropo_q;

	probe_t probe;
	ftok_t  f_head;
	stok_t  s_head;
	ftok_t  f_link [FILTER_ENTRIES];
	stok_t  s_link [SOCKET_ENTRIES];
	fcmd_t  fcmd;
	scmd_t  scmd;

	logic              accept;
	logic              go;
	logic              s_in_rng;
	disp_t             disp_nx;
	logic [HITS_W-1:0] hits_nx;
	logic [SIDX_W-1:0] sidx_nx;
	logic [QCNT_W-1:0] qcnt_nx;
	logic              drop_inc;
	logic              rx_inc;

	assign req.ready = state_q == ST_IDLE;
	assign accept    = req.valid && req.ready;
	assign go        = state_q == ST_FIN && (!out_vld_q || rsp.ready);
	assign s_in_rng  = 7'(idx_q) < 7'(SOCKET_ENTRIES);

	assign probe.sidx  = SIDX_W'(idx_q);
	assign probe.sport = sport_q;
	assign probe.dport = dport_q;
	assign probe.daddr = daddr_q;

	// a token enters both rows the cycle after accept
	always_comb begin
		f_head     = '0;
		f_head.vld = start_q;
		s_head     = '0;
		s_head.vld = start_q;
	end

	// filter row
	for (genvar k = 0; k < FILTER_ENTRIES; k++) begin : g_fcell
		if (k == 0) begin : g_head
			udp_dmx_fcell #(.FIDX(k)) u_cell (
				.clk(clk), .arst_n(arst_n), .probe(probe), .cmd(fcmd),
				.tin(f_head), .tout(f_link[k])
			);
		end else begin : g_body
			udp_dmx_fcell #(.FIDX(k)) u_cell (
				.clk(clk), .arst_n(arst_n), .probe(probe), .cmd(fcmd),
				.tin(f_link[k-1]), .tout(f_link[k])
			);
		end
	end

	// socket row, lowest index sees the token first
	for (genvar k = 0; k < SOCKET_ENTRIES; k++) begin : g_scell
		if (k == 0) begin : g_head
			udp_dmx_scell #(.SIDX(k), .QUEUE_LIMIT(QUEUE_LIMIT)) u_cell (
				.clk(clk), .arst_n(arst_n), .probe(probe), .cmd(scmd),
				.tin(s_head), .tout(s_link[k])
			);
		end else begin : g_body
			udp_dmx_scell #(.SIDX(k), .QUEUE_LIMIT(QUEUE_LIMIT)) u_cell (
				.clk(clk), .arst_n(arst_n), .probe(probe), .cmd(scmd),
				.tin(s_link[k-1]), .tout(s_link[k])
			);
		end
	end

	// final decision from the two collected tokens, plus the table update
	always_comb begin
		disp_nx  = D_DONE;
		hits_nx  = '0;
		sidx_nx  = '0;
		qcnt_nx  = '0;
		drop_inc = 1'b0;
		rx_inc   = 1'b0;
		fcmd     = '0;
		scmd     = '0;
		fcmd.idx = SIDX_W'(idx_q);
		fcmd.used = evalid_q;
		fcmd.src  = sport_q;
		fcmd.dst  = dport_q;
		scmd.idx  = SIDX_W'(idx_q);
		scmd.kind = SC_CLOSE;
		scmd.port = dport_q;
		scmd.addr = daddr_q;
		scmd.handler = handler_q;
		unique case (op_q)
			OP_DATAGRAM: begin
				rx_inc = 1'b1;
				if (len_bad_q) begin
					drop_inc = 1'b1;
					disp_nx  = D_BAD_LEN;
				end else if (check_q && sum_bad_q) begin
					drop_inc = 1'b1;
					disp_nx  = D_BAD_SUM;
				end else if (f_res_q.any) begin
					disp_nx = D_FILTERED;
					hits_nx = f_res_q.hits;
				end else if (!s_res_q.found) begin
					drop_inc = 1'b1;
					disp_nx  = D_NO_SOCK;
				end else begin
					sidx_nx = s_res_q.sel;
					qcnt_nx = s_res_q.selq;
					if (s_res_q.handler) begin
						disp_nx = D_HANDLER;
					end else if (s_res_q.selq < QCNT_W'(QUEUE_LIMIT)) begin
						disp_nx   = D_QUEUED;
						qcnt_nx   = s_res_q.selq + QCNT_W'(1);
						scmd.en   = 1'b1;
						scmd.kind = SC_QUEUE;
						scmd.idx  = s_res_q.sel;
					end else begin
						disp_nx = D_FULL;
					end
				end
			end
			OP_FILTER: begin
				// out-of-range entries match no cell
				fcmd.en = 1'b1;
			end
			OP_BIND: begin
				sidx_nx = SIDX_W'(idx_q);
				if (!s_in_rng) begin
					disp_nx = D_NO_SOCK;
				end else begin
					qcnt_nx = s_res_q.a_q;
					if (s_res_q.in_use) begin
						disp_nx = D_IN_USE;
					end else if (s_res_q.a_used && s_res_q.a_portnz) begin
						disp_nx = D_BOUND;
					end else begin
						scmd.en   = 1'b1;
						scmd.kind = SC_BIND;
					end
				end
			end
			OP_CLOSE: begin
				sidx_nx   = SIDX_W'(idx_q);
				scmd.en   = 1'b1;
				scmd.kind = SC_CLOSE;
			end
			OP_CONSUME: begin
				sidx_nx = SIDX_W'(idx_q);
				qcnt_nx = s_res_q.a_q;
				if (s_in_rng && s_res_q.a_used && s_res_q.a_q != '0) begin
					qcnt_nx   = s_res_q.a_q - QCNT_W'(1);
					scmd.en   = 1'b1;
					scmd.kind = SC_DEQUEUE;
				end else begin
					disp_nx = D_EMPTY;
				end
			end
			default: begin
				disp_nx = D_DONE;
			end
		endcase
		if (!go) begin
			fcmd.en = 1'b0;
			scmd.en = 1'b0;
		end
	end

	// item capture, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(req.operation);
			idx_q     <= req.entry_index;
			sport_q   <= req.source_port;
			dport_q   <= req.dest_port;
			daddr_q   <= req.dest_address;
			len_bad_q <= req.packet_length != req.udp_length;
			sum_bad_q <= req.checksum_failed;
			handler_q <= req.has_handler;
			evalid_q  <= req.entry_valid;
		end
	end

	// sequencer, collected tokens, totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			check_q   <= 1'b1;
			start_q   <= 1'b0;
			f_got_q   <= 1'b0;
			s_got_q   <= 1'b0;
			f_res_q   <= '0;
			s_res_q   <= '0;
			rx_q      <= '0;
			drop_q    <= '0;
			out_vld_q <= 1'b0;
			disp_q    <= D_DONE;
			hits_q    <= '0;
			sidx_q    <= '0;
			qcnt_q    <= '0;
			rxo_q     <= '0;
			dropo_q   <= '0;
		end else begin
			if (cfg_we)
				check_q <= cfg_wdata;
			start_q <= accept;
			if (rsp.ready)
				out_vld_q <= 1'b0;
			if (f_link[FILTER_ENTRIES-1].vld) begin
				f_res_q <= f_link[FILTER_ENTRIES-1];
				f_got_q <= 1'b1;
			end
			if (s_link[SOCKET_ENTRIES-1].vld) begin
				s_res_q <= s_link[SOCKET_ENTRIES-1];
				s_got_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (f_got_q && s_got_q)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (go) begin
						state_q   <= ST_IDLE;
						f_got_q   <= 1'b0;
						s_got_q   <= 1'b0;
						rx_q      <= rx_q + 32'(rx_inc);
						drop_q    <= drop_q + 32'(drop_inc);
						out_vld_q <= 1'b1;
						disp_q    <= disp_nx;
						hits_q    <= hits_nx;
						sidx_q    <= sidx_nx[3:0];
						qcnt_q    <= qcnt_nx[1:0];
						rxo_q     <= rx_q + 32'(rx_inc);
						dropo_q   <= drop_q + 32'(drop_inc);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.disposition    = disp_q;
	assign rsp.filter_hits    = hits_q;
	assign rsp.socket_index   = sidx_q;
	assign rsp.queue_count    = qcnt_q;
	assign rsp.received_count = rxo_q;
	assign rsp.dropped_count  = dropo_q;

	// one token per item reaches the end of each row
	a_ftail_once: assert property (@(posedge clk) disable iff (!arst_n)
		f_link[FILTER_ENTRIES-1].vld |-> !f_got_q && state_q == ST_SCAN)
		else $error("filter token arrived twice or outside a scan");

	a_stail_once: assert property (@(posedge clk) disable iff (!arst_n)
		s_link[SOCKET_ENTRIES-1].vld |-> !s_got_q && state_q == ST_SCAN)
		else $error("socket token arrived twice or outside a scan");

	// a fresh result is loaded only by the final step
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded without a finished item");

	// tables change only while an item is being retired
	a_upd_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(fcmd.en || scmd.en) |-> state_q == ST_FIN && !(fcmd.en && scmd.en))
		else $error("table update outside the final step");

endmodule

@@ rtl/udp_dmx_fcell.sv @@
module udp_dmx_fcell #(
	parameter int FIDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  udp_dmx_pkg::probe_t  probe,
	input  udp_dmx_pkg::fcmd_t   cmd,
	input  udp_dmx_pkg::ftok_t   tin,
	output udp_dmx_pkg::ftok_t   tout
);
	import udp_dmx_pkg::*;

	logic        used_q;
	logic [15:0] src_q;
	logic [15:0] dst_q;
	ftok_t       tok_q;
	ftok_t       tnx;
	logic        match;

	assign match = used_q
		&& (src_q == 16'd0 || src_q == probe.sport)
		&& (dst_q == 16'd0 || dst_q == probe.dport);

	always_comb begin
		tnx      = tin;
		tnx.any  = tin.any | match;
		// entries past the mask width still count in any
		tnx.hits = tin.hits | (HITS_W'(match) << FIDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			src_q  <= '0;
			dst_q  <= '0;
			tok_q  <= '0;
		end else begin
			tok_q <= tnx;
			if (cmd.en && cmd.idx == SIDX_W'(FIDX)) begin
				used_q <= cmd.used;
				if (cmd.used) begin
					src_q <= cmd.src;
					dst_q <= cmd.dst;
				end
			end
		end
	end

	assign tout = tok_q;

endmodule

@@ rtl/udp_dmx_scell.sv @@
module udp_dmx_scell #(
	parameter int SIDX        = 0,
	parameter int QUEUE_LIMIT = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  udp_dmx_pkg::probe_t  probe,
	input  udp_dmx_pkg::scmd_t   cmd,
	input  udp_dmx_pkg::stok_t   tin,
	output udp_dmx_pkg::stok_t   tout
);
	import udp_dmx_pkg::*;

	localparam int QW = $clog2(QUEUE_LIMIT + 1);

	logic          used_q;
	logic [15:0]   port_q;
	logic [31:0]   addr_q;
	logic          handler_q;
	logic [QW-1:0] queue_q;
	stok_t         tok_q;
	stok_t         tnx;
	logic          port_eq;
	logic          hit;

	assign port_eq = used_q && port_q == probe.dport;
	assign hit     = port_eq && (addr_q == 32'd0 || addr_q == probe.daddr);

	always_comb begin
		tnx        = tin;
		tnx.in_use = tin.in_use | port_eq;
		// first match along the row wins
		if (hit && !tin.found) begin
			tnx.found   = 1'b1;
			tnx.sel     = SIDX_W'(SIDX);
			tnx.handler = handler_q;
			tnx.selq    = QCNT_W'(queue_q);
		end
		if (probe.sidx == SIDX_W'(SIDX)) begin
			tnx.a_used   = used_q;
			tnx.a_portnz = port_q != 16'd0;
			tnx.a_q      = QCNT_W'(queue_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			port_q    <= '0;
			addr_q    <= '0;
			handler_q <= 1'b0;
			queue_q   <= '0;
			tok_q     <= '0;
		end else begin
			tok_q <= tnx;
			if (cmd.en && cmd.idx == SIDX_W'(SIDX)) begin
				unique case (cmd.kind)
					SC_QUEUE: begin
						queue_q <= queue_q + QW'(1);
					end
					SC_DEQUEUE: begin
						queue_q <= queue_q - QW'(1);
					end
					SC_BIND: begin
						// fresh entry starts clear; reuse keeps address if none given
						used_q    <= 1'b1;
						port_q    <= cmd.port;
						handler_q <= cmd.handler;
						if (cmd.addr != 32'd0)
							addr_q <= cmd.addr;
						else if (!used_q)
							addr_q <= '0;
						if (!used_q)
							queue_q <= '0;
					end
					SC_CLOSE: begin
						used_q    <= 1'b0;
						port_q    <= '0;
						addr_q    <= '0;
						handler_q <= 1'b0;
						queue_q   <= '0;
					end
					default: begin
						queue_q <= queue_q;
					end
				endcase
			end
		end
	end

	assign tout = tok_q;

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import udp_dmx_pkg::*;

	// table sizes of the default build, and the per-socket queue depth
	localparam int N_ENT = 16;
	localparam int Q_LIMIT = 2;
	// accept to next accept at the defaults, plus margin
	localparam int LAT_CYCLES = 24;
	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT = 200000;

	// one request item as queued for the driver, with the idle count after it
	typedef struct {
		op_t         op;
		logic [3:0]  entry;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] daddr;
		logic [15:0] plen;
		logic [15:0] ulen;
		logic        sum_bad;
		logic        handler;
		logic        fvalid;
		int unsigned gap;
	} udp_item_t;

	// what the block should answer for one request item
	typedef struct {
		disp_t       disp;
		logic [15:0] hits;
		logic [3:0]  sock;
		logic [1:0]  qcnt;
		logic [31:0] rx_total;
		logic [31:0] drop_total;
	} udp_verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	udp_dmx_req_if req_ch();
	udp_dmx_rsp_if rsp_ch();

	udp_port_demux_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// shadow copy of the tables, totals and check_enable
	// ---------------------------------------------------------------
	bit        check_en;
	bit        flt_used [N_ENT];
	bit [15:0] flt_src [N_ENT];
	bit [15:0] flt_dst [N_ENT];
	bit        sock_used [N_ENT];
	bit [15:0] sock_port [N_ENT];
	bit [31:0] sock_addr [N_ENT];
	bit        sock_handler [N_ENT];
	bit [1:0]  sock_queue [N_ENT];
	bit [31:0] rx_total;
	bit [31:0] drop_total;

	udp_item_t    pending_items[$];
	udp_verdict_t expected_verdicts[$];
	udp_item_t    on_wire;

	int unsigned send_idle;
	int unsigned recv_stall;
	bit          send_calm;
	bit          rsp_calm;
	int          items_sent;
	int          results_seen;
	int          fail_count;
	int          cycle_count;
	logic [15:0] disp_seen;

	function automatic void clear_sock(int s);
		sock_used[s]    = 1'b0;
		sock_port[s]    = '0;
		sock_addr[s]    = '0;
		sock_handler[s] = 1'b0;
		sock_queue[s]   = '0;
	endfunction

	// works out the answer to one accepted item and updates the shadow state
	function automatic udp_verdict_t classify(udp_item_t it);
		udp_verdict_t v;
		bit           any_hit;
		bit           found;
		bit           port_taken;
		int           s;
		int           i;
		v.disp     = D_DONE;
		v.hits     = '0;
		v.sock     = '0;
		v.qcnt     = '0;
		any_hit    = 1'b0;
		found      = 1'b0;
		port_taken = 1'b0;
		s          = 0;
		case (it.op)
			OP_DATAGRAM: begin
				rx_total++;
				if (it.plen != it.ulen) begin
					drop_total++;
					v.disp = D_BAD_LEN;
				end else if (check_en && it.sum_bad) begin
					drop_total++;
					v.disp = D_BAD_SUM;
				end else begin
					// every filter is looked at, the hit mask collects all of them
					for (i = 0; i < N_ENT; i++) begin
						if (flt_used[i] && (flt_src[i] == 0 || flt_src[i] == it.sport) &&
								(flt_dst[i] == 0 || flt_dst[i] == it.dport)) begin
							any_hit   = 1'b1;
							v.hits[i] = 1'b1;
						end
					end
					if (any_hit) begin
						v.disp = D_FILTERED;
					end else begin
						// walk downwards so the lowest matching socket wins
						for (i = N_ENT - 1; i >= 0; i--) begin
							if (sock_used[i] && sock_port[i] == it.dport &&
									(sock_addr[i] == 0 || sock_addr[i] == it.daddr)) begin
								found = 1'b1;
								s     = i;
							end
						end
						if (!found) begin
							drop_total++;
							v.disp = D_NO_SOCK;
						end else begin
							v.sock = 4'(s);
							if (sock_handler[s]) begin
								v.disp = D_HANDLER;
							end else if (sock_queue[s] < Q_LIMIT) begin
								sock_queue[s]++;
								v.disp = D_QUEUED;
							end else begin
								v.disp = D_FULL;
							end
							v.qcnt = sock_queue[s];
						end
					end
				end
			end
			OP_FILTER: begin
				if (it.fvalid) begin
					flt_used[it.entry] = 1'b1;
					flt_src[it.entry]  = it.sport;
					flt_dst[it.entry]  = it.dport;
				end else begin
					flt_used[it.entry] = 1'b0;
				end
			end
			OP_BIND: begin
				v.sock = it.entry;
				// the addressed entry counts too when checking the port
				for (i = 0; i < N_ENT; i++)
					if (sock_used[i] && sock_port[i] == it.dport)
						port_taken = 1'b1;
				if (port_taken) begin
					v.disp = D_IN_USE;
				end else if (sock_used[it.entry] && sock_port[it.entry] != 0) begin
					v.disp = D_BOUND;
				end else begin
					if (!sock_used[it.entry])
						clear_sock(it.entry);
					sock_used[it.entry] = 1'b1;
					if (it.daddr != 0)
						sock_addr[it.entry] = it.daddr;
					if (it.dport != 0)
						sock_port[it.entry] = it.dport;
					sock_handler[it.entry] = it.handler;
				end
				v.qcnt = sock_queue[it.entry];
			end
			OP_CLOSE: begin
				v.sock = it.entry;
				clear_sock(it.entry);
			end
			OP_CONSUME: begin
				v.sock = it.entry;
				if (sock_used[it.entry] && sock_queue[it.entry] > 0) begin
					sock_queue[it.entry]--;
				end else begin
					v.disp = D_EMPTY;
				end
				v.qcnt = sock_queue[it.entry];
			end
			default: v.disp = D_DONE;
		endcase
		v.rx_total   = rx_total;
		v.drop_total = drop_total;
		return v;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	function automatic int unsigned draw_gap();
		return send_calm ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic udp_item_t mk(op_t op, int unsigned entry, logic [15:0] sport,
			logic [15:0] dport, logic [31:0] daddr, logic [15:0] plen, logic [15:0] ulen,
			int unsigned sum_bad, int unsigned handler, int unsigned fvalid);
		udp_item_t it;
		it.op      = op;
		it.entry   = 4'(entry);
		it.sport   = sport;
		it.dport   = dport;
		it.daddr   = daddr;
		it.plen    = plen;
		it.ulen    = ulen;
		it.sum_bad = 1'(sum_bad);
		it.handler = 1'(handler);
		it.fvalid  = 1'(fvalid);
		it.gap     = draw_gap();
		return it;
	endfunction

	// a handful of ports and addresses recur so binds, filters and datagrams meet
	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0035;
			3: return 16'h1234;
			4: return 16'h8000;
			5: return 16'h00A1;
			6: return 16'h1234;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(0, 5))
			0, 1: return 32'h0000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0A00_0001;
			4: return 32'hC0A8_0001;
			default: return $urandom;
		endcase
	endfunction

	function automatic udp_item_t rand_item();
		udp_item_t   it;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			it.op = OP_DATAGRAM;
		else if (roll < 58)
			it.op = OP_FILTER;
		else if (roll < 75)
			it.op = OP_BIND;
		else if (roll < 83)
			it.op = OP_CLOSE;
		else
			it.op = OP_CONSUME;
		// mostly a few low entries, so sockets fill, drain and get reused
		it.entry   = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
			: $urandom_range(0, 5));
		it.sport   = pick_port();
		it.dport   = pick_port();
		it.daddr   = pick_addr();
		it.plen    = 16'($urandom_range(0, 1) ? $urandom_range(8, 1500)
			: $urandom_range(0, 65535));
		it.ulen    = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 65535)) : it.plen;
		it.sum_bad = ($urandom_range(0, 3) == 0);
		it.handler = ($urandom_range(0, 2) == 0);
		it.fvalid  = 1'($urandom_range(0, 1));
		it.gap     = draw_gap();
		return it;
	endfunction

	// sender halts until every answer is back, then lets the block settle
	task automatic wait_idle();
		while (pending_items.size() != 0 || req_ch.valid || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (LAT_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// request driver: takes the next queued item once the last one is gone
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_idle    <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			// item accepted at this edge: predict its answer now
			if (req_ch.valid) begin
				expected_verdicts.push_back(classify(on_wire));
				items_sent++;
			end
			if (send_idle > 0) begin
				req_ch.valid <= 1'b0;
				send_idle    <= send_idle - 1;
			end else if (pending_items.size() > 0) begin
				on_wire = pending_items.pop_front();
				req_ch.valid           <= 1'b1;
				req_ch.operation       <= on_wire.op;
				req_ch.entry_index     <= on_wire.entry;
				req_ch.source_port     <= on_wire.sport;
				req_ch.dest_port       <= on_wire.dport;
				req_ch.dest_address    <= on_wire.daddr;
				req_ch.packet_length   <= on_wire.plen;
				req_ch.udp_length      <= on_wire.ulen;
				req_ch.checksum_failed <= on_wire.sum_bad;
				req_ch.has_handler     <= on_wire.handler;
				req_ch.entry_valid     <= on_wire.fvalid;
				send_idle              <= on_wire.gap;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor: random back-pressure, compares against oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		udp_verdict_t want;
		int unsigned  n;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_stall   <= 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("result with nothing outstanding: disposition %0d", rsp_ch.disposition);
				fail_count++;
			end else begin
				want = expected_verdicts.pop_front();
				results_seen++;
				disp_seen[want.disp] = 1'b1;
				if (rsp_ch.disposition !== want.disp) begin
					$error("disposition: expected %0d, got %0d", want.disp, rsp_ch.disposition);
					fail_count++;
				end
				if (rsp_ch.filter_hits !== want.hits) begin
					$error("filter_hits: expected %h, got %h", want.hits, rsp_ch.filter_hits);
					fail_count++;
				end
				if (rsp_ch.socket_index !== want.sock) begin
					$error("socket_index: expected %0d, got %0d", want.sock, rsp_ch.socket_index);
					fail_count++;
				end
				if (rsp_ch.queue_count !== want.qcnt) begin
					$error("queue_count: expected %0d, got %0d", want.qcnt, rsp_ch.queue_count);
					fail_count++;
				end
				if (rsp_ch.received_count !== want.rx_total) begin
					$error("received_count: expected %0d, got %0d", want.rx_total,
						rsp_ch.received_count);
					fail_count++;
				end
				if (rsp_ch.dropped_count !== want.drop_total) begin
					$error("dropped_count: expected %0d, got %0d", want.drop_total,
						rsp_ch.dropped_count);
					fail_count++;
				end
			end
			// now and then switch between stalling and a stretch of steady ready
			if ($urandom_range(0, 24) == 0)
				rsp_calm = !rsp_calm;
			n = rsp_calm ? 0 : $urandom_range(0, 18);
			rsp_ch.ready <= (n == 0);
			recv_stall   <= (n == 0) ? 0 : n - 1;
		end else if (recv_stall > 0) begin
			recv_stall <= recv_stall - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
				expected_verdicts.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus: directed opening, then three random phases, each at a new
	// check_enable setting written while the block is idle
	// ---------------------------------------------------------------
	initial begin
		int unsigned phase;
		int unsigned k;
		// known levels on every input from time zero
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.operation       = OP_DATAGRAM;
		req_ch.entry_index     = '0;
		req_ch.source_port     = '0;
		req_ch.dest_port       = '0;
		req_ch.dest_address    = '0;
		req_ch.packet_length   = '0;
		req_ch.udp_length      = '0;
		req_ch.checksum_failed = 1'b0;
		req_ch.has_handler     = 1'b0;
		req_ch.entry_valid     = 1'b0;
		rsp_ch.ready           = 1'b0;
		check_en               = 1'b1;
		cycle_count            = 0;
		disp_seen              = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty tables: nothing to deliver to
		pending_items.push_back(mk(OP_DATAGRAM, 0, 16'h0000, 16'h0000, 32'h0, 16'h0, 16'h0,
			0, 0, 0));
		// length mismatch wins over a failed checksum
		pending_items.push_back(mk(OP_DATAGRAM, 15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'h0000, 1, 1, 1));
		// failed checksum with checking on after reset
		pending_items.push_back(mk(OP_DATAGRAM, 0, 16'h0035, 16'h1234, 32'h0A00_0001,
			16'hFFFF, 16'hFFFF, 1, 0, 0));
		// bind, then the port-in-use and already-bound refusals
		pending_items.push_back(mk(OP_BIND, 0, 16'h0, 16'h1234, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		pending_items.push_back(mk(OP_BIND, 1, 16'h0, 16'h1234, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		pending_items.push_back(mk(OP_BIND, 0, 16'h0, 16'h5555, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		// fill the queue to its limit and one past it
		repeat (3)
			pending_items.push_back(mk(OP_DATAGRAM, 0, 16'h0035, 16'h1234, 32'hC0A8_0001,
				16'd8, 16'd8, 0, 0, 0));
		pending_items.push_back(mk(OP_CONSUME, 0, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		// consume on an unused entry
		pending_items.push_back(mk(OP_CONSUME, 2, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		// handler socket at the top entry with a fixed address
		pending_items.push_back(mk(OP_BIND, 15, 16'h0, 16'hFFFF, 32'hFFFF_FFFF, 16'h0, 16'h0,
			0, 1, 0));
		pending_items.push_back(mk(OP_DATAGRAM, 0, 16'h0001, 16'hFFFF, 32'hFFFF_FFFF,
			16'd20, 16'd20, 0, 0, 0));
		// same port, other address: no socket
		pending_items.push_back(mk(OP_DATAGRAM, 0, 16'h0001, 16'hFFFF, 32'h0000_0001,
			16'd20, 16'd20, 0, 0, 0));
		// allocated but unbound socket sits on port zero
		pending_items.push_back(mk(OP_BIND, 3, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		pending_items.push_back(mk(OP_DATAGRAM, 0, 16'h0007, 16'h0000, 32'h1234_5678,
			16'd8, 16'd8, 0, 0, 0));
		pending_items.push_back(mk(OP_BIND, 4, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		// an unbound socket may still take a port, keeping its queue
		pending_items.push_back(mk(OP_BIND, 3, 16'h0, 16'h0777, 32'h0A00_0001, 16'h0, 16'h0,
			0, 0, 0));
		// two filters, top and bottom entry, both hit one datagram
		pending_items.push_back(mk(OP_FILTER, 15, 16'h0000, 16'h1234, 32'h0, 16'h0, 16'h0,
			0, 0, 1));
		pending_items.push_back(mk(OP_FILTER, 0, 16'hFFFF, 16'h0000, 32'h0, 16'h0, 16'h0,
			0, 0, 1));
		pending_items.push_back(mk(OP_DATAGRAM, 0, 16'hFFFF, 16'h1234, 32'hC0A8_0001,
			16'd8, 16'd8, 0, 0, 0));
		pending_items.push_back(mk(OP_FILTER, 15, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		pending_items.push_back(mk(OP_FILTER, 0, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		// close twice, the second on an unused entry, then nothing to consume
		repeat (2)
			pending_items.push_back(mk(OP_CLOSE, 0, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0));
		pending_items.push_back(mk(OP_CONSUME, 0, 16'h0, 16'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0));

		for (phase = 0; phase < 3; phase++) begin
			wait_idle();
			// check_enable goes 0, 1, 0 across the phases
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= phase[0];
			check_en   = phase[0];
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			for (k = 0; k < RANDOM_ITEMS / 3; k++) begin
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				pending_items.push_back(rand_item());
			end
		end
		wait_idle();

		$display("%0d items sent, %0d answers checked, %0d of 11 dispositions seen",
			items_sent, results_seen, $countones(disp_seen));
		$display("check_enable run at both settings over filters, binds, queues and closes");
		if (fail_count == 0 && expected_verdicts.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ udp_port_demux_core.f @@
rtl/udp_dmx_pkg.sv
rtl/udp_dmx_ifs.sv
rtl/udp_dmx_fcell.sv
rtl/udp_dmx_scell.sv
rtl/udp_port_demux_core.sv
tb/testbench.sv
